/* design/lbm_pkg.sv */
// ============================================================================
// Loop bracket matcher package
// Shared constants and the command and status bundles that pass between the
// controller and the datapath of the loop bracket matcher.
// ============================================================================
package lbm_pkg;

  // Field widths of one block and of one result.
  localparam int ADDR_W      = 8;
  localparam int KIND_W      = 2;
  localparam int TOUCH_W     = 4;
  localparam int OUT_TDATA_W = 16;

  // Block kinds. Any other code counts as a plain block.
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming block
    logic seed;       // start a slot walk at the cursor
    logic pop;        // remove the top open start
    logic latch_err;  // end with nothing open: record it and stop
    logic step;       // move the walk one slot on
    logic commit;     // store the block in the slot that the walk found
    logic flag_over;  // start dropped, table or stack full
    logic emit;       // load the result register
  } lbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_op;     // held block is a start that must be handled
    logic end_op;       // held block is an end that must be handled
    logic stack_full;
    logic stack_empty;
    logic walk_hit;     // walk stands on a usable slot
    logic walk_miss;    // walk ran off the table
    logic out_free;     // result register can take a new result
  } lbm_status_t;

endpackage

/* design/lbm_ctrl.sv */
// ============================================================================
// Loop bracket matcher controller
// Sequences one block at a time: capture, classify, walk the pair table one
// slot per cycle, then hand the result to the output register.
// ============================================================================
module lbm_ctrl
  import lbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  lbm_status_t status,
  output lbm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Requests are taken only between blocks.
  assign s_axis_tready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.start_op) begin
          if (status.stack_full) begin
            cmd.flag_over = 1'b1;
            state_next    = ST_EMIT;
          end else begin
            cmd.seed   = 1'b1;
            state_next = ST_WALK;
          end
        end else if (status.end_op) begin
          if (status.stack_empty) begin
            cmd.latch_err = 1'b1;
            state_next    = ST_EMIT;
          end else begin
            cmd.pop    = 1'b1;
            cmd.seed   = 1'b1;
            state_next = ST_WALK;
          end
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_WALK: begin
        if (status.walk_hit) begin
          cmd.commit = 1'b1;
          state_next = ST_EMIT;
        end else if (status.walk_miss) begin
          // A start with no free slot is dropped; an end with no open slot
          // simply writes nothing.
          cmd.flag_over = status.start_op;
          state_next    = ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/lbm_datapath.sv */
// ============================================================================
// Loop bracket matcher datapath
// Holds the open-start count and bottom entry, the slot cursor, the pair
// table occupancy, the slot walker and the result register.
// ============================================================================
module lbm_datapath
  import lbm_pkg::*;
#(
  parameter int LOOP_SLOTS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ADDR_W-1:0]      s_axis_tdata,
  input  logic [KIND_W-1:0]      s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  lbm_cmd_t               cmd,
  output lbm_status_t            status,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int DEPTH  = 2 * LOOP_SLOTS;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = $clog2(LOOP_SLOTS + 2);
  localparam int IDX_W  = (LOOP_SLOTS > 1) ? $clog2(LOOP_SLOTS) : 1;
  localparam int PAD_W  = OUT_TDATA_W - TOUCH_W - ADDR_W - 1;

  // Held block.
  logic [ADDR_W-1:0] item_addr;
  logic [KIND_W-1:0] item_kind;
  logic              item_last;

  // Open starts. Only the bottom entry is ever reported, so the stack is
  // kept as a depth count plus its bottom address.
  logic [CNT_W-1:0]  stack_count;
  logic [ADDR_W-1:0] stack_bottom;
  logic              error_latched;

  // Pair table. Stored addresses are never zero, so only occupancy is kept.
  logic [SLOT_W-1:0]     slot_cursor;
  logic [LOOP_SLOTS-1:0] start_used;
  logic [LOOP_SLOTS-1:0] end_used;

  // Slot walker and result being built.
  logic [SLOT_W-1:0]  walk_slot;
  logic [TOUCH_W-1:0] touched;
  logic               over;

  // Result register.
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   out_last;

  logic                 active;
  logic                 is_start;
  logic [SLOT_W-1:0]    walk_m1;
  logic [IDX_W-1:0]     walk_idx;
  logic                 in_range;
  logic                 slot_busy;
  logic [SLOT_W-1:0]    seed_slot;
  logic [SLOT_W+TOUCH_W-1:0] touch_ext;
  logic [ADDR_W-1:0]    verdict;

  // Classification of the held block.
  assign active   = !error_latched && (item_addr != '0);
  assign is_start = (item_kind == KIND_START);

  // Walker position and the table entry under it.
  assign walk_m1   = walk_slot - 1'b1;
  assign walk_idx  = walk_m1[IDX_W-1:0];
  assign in_range  = (walk_slot != '0) && (walk_slot <= SLOT_W'(LOOP_SLOTS));
  assign slot_busy = is_start ? start_used[walk_idx] : end_used[walk_idx];
  assign seed_slot = (slot_cursor > SLOT_W'(LOOP_SLOTS)) ? SLOT_W'(LOOP_SLOTS)
                                                          : slot_cursor;
  assign touch_ext = {{TOUCH_W{1'b0}}, walk_slot};
  assign verdict   = item_last ? stack_bottom : '0;

  always_comb begin
    status             = '0;
    status.start_op    = active && is_start;
    status.end_op      = active && (item_kind == KIND_END);
    status.stack_full  = (stack_count >= CNT_W'(DEPTH));
    status.stack_empty = (stack_count == '0);
    status.walk_hit    = in_range && !slot_busy;
    status.walk_miss   = !in_range;
    status.out_free    = !out_valid || m_axis_tready;
  end

  // Block capture, walker and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_addr <= s_axis_tdata;
      item_kind <= s_axis_tuser;
      item_last <= s_axis_tlast;
      touched   <= '0;
      over      <= 1'b0;
    end
    if (cmd.seed) begin
      walk_slot <= seed_slot;
    end else if (cmd.step) begin
      walk_slot <= is_start ? (walk_slot + 1'b1) : walk_m1;
    end
    if (cmd.commit) begin
      touched <= touch_ext[TOUCH_W-1:0];
    end
    if (cmd.flag_over) begin
      over <= 1'b1;
    end
    if (cmd.emit) begin
      out_data <= {{PAD_W{1'b0}}, over, verdict, touched};
      out_last <= item_last;
    end
  end

  // Matching state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      stack_bottom  <= '0;
      error_latched <= 1'b0;
      slot_cursor   <= SLOT_W'(1);
      start_used    <= '0;
      end_used      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.pop) begin
        stack_count <= stack_count - 1'b1;
        if (stack_count == CNT_W'(1)) begin
          stack_bottom <= '0;
        end
      end
      if (cmd.latch_err) begin
        stack_bottom  <= item_addr;
        error_latched <= 1'b1;
      end
      if (cmd.commit) begin
        slot_cursor <= walk_slot;
        if (is_start) begin
          start_used[walk_idx] <= 1'b1;
          stack_count          <= stack_count + 1'b1;
          if (stack_count == '0) begin
            stack_bottom <= item_addr;
          end
        end else begin
          end_used[walk_idx] <= 1'b1;
        end
      end
      // The last block of a program returns all matching state to its idle values.
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (item_last) begin
          stack_count   <= '0;
          stack_bottom  <= '0;
          error_latched <= 1'b0;
          slot_cursor   <= SLOT_W'(1);
          start_used    <= '0;
          end_used      <= '0;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  // The open count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(DEPTH))
    else $error("open-start count beyond stack depth");

  // Once an error is latched, nothing can be open.
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> (stack_count == '0))
    else $error("error latched with open starts");

  // With no error and nothing open, the bottom entry is clear.
  a_bottom_clear: assert property (@(posedge clk) disable iff (rst)
    (!error_latched && stack_count == '0) |-> (stack_bottom == '0))
    else $error("stale bottom entry");

  // The cursor always points into the pair table.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (slot_cursor != '0) && (slot_cursor <= SLOT_W'(LOOP_SLOTS)))
    else $error("slot cursor out of range");

endmodule

/* design/loop_bracket_matcher_unit.sv */
// ============================================================================
// Loop bracket matcher
// Checks loop-start and loop-end blocks of a program for balance and reports
// the pair slot touched by each block and a verdict on the last one.
// ============================================================================
// Blocks are taken one at a time. A block that is ignored (address zero, a
// plain kind, or anything after an unmatched end) and an end that finds
// nothing open skip the walk; a start or end that walks the pair table
// checks one slot per cycle, stepping over each occupied slot, until it
// finds a slot or runs off the table. The result sits in an output register,
// so the next block is taken while it waits.
// The pair table holds LOOP_SLOTS pairs and the open stack twice as many
// entries; a start that finds either full is dropped and flagged. After the
// last block of a program all matching state returns to its idle values at
// once.
module loop_bracket_matcher_unit
  import lbm_pkg::*;
#(
  parameter int LOOP_SLOTS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ADDR_W-1:0]      s_axis_tdata,   // [7:0] block_address
  input  logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] block_kind
  input  logic                   s_axis_tlast,   // last_block
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] slot_touched,
                                                 // [11:4] mismatch_address,
                                                 // [12] capacity_exceeded
  output logic                   m_axis_tlast    // verdict_valid
);

  lbm_cmd_t    cmd;
  lbm_status_t status;

  // Sequencer.
  lbm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Matching state and result register.
  lbm_datapath #(
    .LOOP_SLOTS (LOOP_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* bench/loop_bracket_matcher_unit_test.sv */
// ============================================================================
// Loop bracket matcher testbench
// Drives whole programs of blocks into the matcher and checks every result
// against a cycle-free model of the bracket stack and pair table, or a typed
// directed row's own expectation. A short table of hand-picked blocks comes
// first, followed by random programs that are mostly balanced, with
// overflowing, broken and noisy ones mixed in. Both stream sides pause at random.
// ============================================================================
module loop_bracket_matcher_unit_test
  import lbm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOOP_SLOTS  = 8;
  localparam int STACK_DEPTH = 2 * LOOP_SLOTS;
  localparam int BLOCK_GOAL  = 1450;

  // Kinds that the package leaves out: both count as plain blocks.
  localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
    logic              last;
  } block_t;

  typedef struct packed {
    logic [TOUCH_W-1:0] touch;
    logic               verdict;
    logic [ADDR_W-1:0]  mis_addr;
    logic               over;
  } report_t;

  // One row of the directed table; a typed row carries its own expectation.
  typedef struct packed {
    block_t  blk;
    logic    typed;
    report_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ADDR_W-1:0]      s_axis_tdata = '0;   // [7:0] block_address
  logic [KIND_W-1:0]      s_axis_tuser = '0;   // [1:0] block_kind
  logic                   s_axis_tlast = 1'b0; // last_block
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [3:0] slot_touched,
                                               // [11:4] mismatch_address,
                                               // [12] capacity_exceeded
  logic                   m_axis_tlast;        // verdict_valid

  report_t awaited_reports[$];
  row_t    directed_rows[$];
  block_t  program_blocks[$];
  int      fault_count = 0;
  int      counted_blocks = 0;
  int      sent_count = 0;
  int      taken_count = 0;
  bit      calm_tx = 1'b0;
  bit      calm_rx = 1'b0;

  // Model state: open stack, pair table and the latched error.
  logic [ADDR_W-1:0] open_addr [0:STACK_DEPTH-1];
  int                open_depth;
  int                cursor;
  logic [ADDR_W-1:0] slot_start [1:LOOP_SLOTS];
  logic [ADDR_W-1:0] slot_end [1:LOOP_SLOTS];
  bit                halted;

  loop_bracket_matcher_unit #(
    .LOOP_SLOTS(LOOP_SLOTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Return the model to its idle state, as after reset or after a program.
  function automatic void clear_matcher();
    for (int i = 0; i < STACK_DEPTH; i++) open_addr[i] = '0;
    for (int i = 1; i <= LOOP_SLOTS; i++) begin
      slot_start[i] = '0;
      slot_end[i]   = '0;
    end
    open_depth = 0;
    cursor     = 1;
    halted     = 1'b0;
  endfunction

  // Apply one block to the model and return the result it should produce.
  function automatic report_t match_block(block_t blk);
    report_t r;
    int      c;
    r = '0;
    if (!halted && blk.addr != 0) begin
      if (blk.kind == KIND_START) begin
        c = cursor;
        while (c >= 1 && c <= LOOP_SLOTS && slot_start[c] != 0) c++;
        if (c < 1 || c > LOOP_SLOTS || open_depth >= STACK_DEPTH) begin
          r.over = 1'b1;
        end else begin
          open_addr[open_depth] = blk.addr;
          open_depth++;
          cursor        = c;
          slot_start[c] = blk.addr;
          r.touch       = c[TOUCH_W-1:0];
        end
      end else if (blk.kind == KIND_END) begin
        if (open_depth > 0) begin
          open_depth--;
          open_addr[open_depth] = '0;
          c = (cursor > LOOP_SLOTS) ? LOOP_SLOTS : cursor;
          while (c >= 1 && slot_end[c] != 0) c--;
          if (c >= 1) begin
            slot_end[c] = blk.addr;
            cursor      = c;
            r.touch     = c[TOUCH_W-1:0];
          end
        end else begin
          // An end with nothing open is kept at the stack bottom for the verdict.
          open_addr[0] = blk.addr;
          halted       = 1'b1;
        end
      end
    end
    r.verdict = blk.last;
    if (blk.last) begin
      r.mis_addr = open_addr[0];
      clear_matcher();
    end
    return r;
  endfunction

  task automatic report_fault(string what, int got, int want);
    fault_count++;
    if (fault_count <= 100)
      $display("ERROR %0t result %0d: %s got %0h expected %0h",
               $realtime, taken_count, what, got, want);
  endtask

  task automatic add_row(logic [ADDR_W-1:0] addr, logic [KIND_W-1:0] kind, logic last,
                         logic typed, logic [TOUCH_W-1:0] touch, logic verdict,
                         logic [ADDR_W-1:0] mis_addr, logic over);
    row_t r;
    r.blk   = '{addr, kind, last};
    r.typed = typed;
    r.want  = '{touch, verdict, mis_addr, over};
    directed_rows.push_back(r);
  endtask

  // Offer one block; on acceptance queue either the given or the modeled result.
  task automatic send_block(block_t blk, logic use_given, report_t given);
    int      gap;
    report_t modeled;
    gap = calm_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk.addr;
    s_axis_tuser  <= blk.kind;
    s_axis_tlast  <= blk.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    modeled = match_block(blk);
    awaited_reports.push_back(use_given ? given : modeled);
    counted_blocks++;
    sent_count++;
    if (sent_count % 96 == 0) calm_tx = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [ADDR_W-1:0] any_addr();
    return ADDR_W'($urandom_range(1, 255));
  endfunction

  // A block that leaves the brackets alone: an empty position or a plain kind.
  function automatic block_t filler_block();
    block_t b;
    b.last = 1'b0;
    if ($urandom_range(0, 2) == 0) begin
      b.addr = '0;
      b.kind = KIND_W'($urandom_range(0, 3));
    end else begin
      b.addr = any_addr();
      b.kind = $urandom_range(0, 1) ? KIND_PLAIN : KIND_SPARE;
    end
    return b;
  endfunction

  // Build one random program: mostly balanced nests, some that overflow the
  // table, some with stray ends or unclosed starts, and some pure noise.
  task automatic build_program();
    int     shape;
    int     noise;
    int     left;
    int     depth;
    int     n;
    block_t b;
    program_blocks.delete();
    shape = $urandom_range(0, 9);
    noise = $urandom_range(0, 30);
    b.last = 1'b0;
    if (shape <= 6) begin
      left  = $urandom_range(0, LOOP_SLOTS);
      depth = 0;
      while (left > 0 || depth > 0) begin
        if ($urandom_range(0, 99) < noise) program_blocks.push_back(filler_block());
        b.addr = any_addr();
        if (left > 0 && (depth == 0 || $urandom_range(0, 1) == 1)) begin
          b.kind = KIND_START;
          left--;
          depth++;
        end else begin
          b.kind = KIND_END;
          depth--;
        end
        program_blocks.push_back(b);
      end
    end else if (shape == 7) begin
      n = $urandom_range(LOOP_SLOTS + 1, LOOP_SLOTS + 4);
      for (int i = 0; i < n; i++) begin
        b.addr = any_addr();
        b.kind = KIND_START;
        program_blocks.push_back(b);
      end
      n = $urandom_range(0, n);
      for (int i = 0; i < n; i++) begin
        b.addr = any_addr();
        b.kind = KIND_END;
        program_blocks.push_back(b);
      end
    end else if (shape == 8) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        b.addr = any_addr();
        b.kind = $urandom_range(0, 1) ? KIND_START : KIND_END;
        program_blocks.push_back(b);
      end
    end else begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        b.addr = ($urandom_range(0, 4) == 0) ? 8'd0 : any_addr();
        b.kind = KIND_W'($urandom_range(0, 3));
        program_blocks.push_back(b);
      end
    end
    if (program_blocks.size() == 0 || $urandom_range(0, 3) == 0)
      program_blocks.push_back(filler_block());
    program_blocks[program_blocks.size() - 1].last = 1'b1;
  endtask

  // Result side: random stalls, then compare each result with the oldest one due.
  initial begin : result_check
    int      stall;
    report_t got;
    report_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got.touch    = m_axis_tdata[3:0];
      got.mis_addr = m_axis_tdata[11:4];
      got.over     = m_axis_tdata[12];
      got.verdict  = m_axis_tlast;
      taken_count++;
      if (awaited_reports.size() == 0) begin
        report_fault("result with none outstanding", int'(m_axis_tdata), 0);
      end else begin
        want = awaited_reports.pop_front();
        if (got.touch !== want.touch)
          report_fault("slot_touched", int'(got.touch), int'(want.touch));
        if (got.verdict !== want.verdict)
          report_fault("verdict_valid", int'(got.verdict), int'(want.verdict));
        if (got.mis_addr !== want.mis_addr)
          report_fault("mismatch_address", int'(got.mis_addr), int'(want.mis_addr));
        if (got.over !== want.over)
          report_fault("capacity_exceeded", int'(got.over), int'(want.over));
      end
      if (taken_count % 80 == 0) calm_rx = ($urandom_range(0, 3) == 0);
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #5_000_000;
    $display("loop_bracket_matcher_unit_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    bit drained;
    drained = 1'b0;
    clear_matcher();

    // Plain use: empty position, one pair, unknown kind, then a balanced verdict.
    add_row(8'h00, KIND_START, 1'b0, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h10, KIND_START, 1'b0, 1'b1, 4'd1, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, KIND_SPARE, 1'b0, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h20, KIND_PLAIN, 1'b0, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h21, KIND_END,   1'b0, 1'b1, 4'd1, 1'b0, 8'h00, 1'b0);
    add_row(8'h00, KIND_END,   1'b1, 1'b1, 4'd0, 1'b1, 8'h00, 1'b0);
    // Fill every slot, then one start too many; the verdict names the outermost.
    add_row(8'h01, KIND_START, 1'b0, 1'b1, 4'd1, 1'b0, 8'h00, 1'b0);
    for (int i = 2; i <= LOOP_SLOTS; i++)
      add_row(ADDR_W'(i), KIND_START, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0);
    add_row(8'h80, KIND_START, 1'b0, 1'b1, 4'd0, 1'b0, 8'h00, 1'b1);
    add_row(8'hFE, KIND_END,   1'b0, 1'b0, '0, 1'b0, '0, 1'b0);
    add_row(8'h01, KIND_PLAIN, 1'b1, 1'b1, 4'd0, 1'b1, 8'h01, 1'b0);
    // End with nothing open: everything after it is ignored until the verdict.
    add_row(8'hAA, KIND_END,   1'b0, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h33, KIND_START, 1'b0, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h44, KIND_END,   1'b1, 1'b1, 4'd0, 1'b1, 8'hAA, 1'b0);
    // One-block programs.
    add_row(8'h55, KIND_START, 1'b1, 1'b1, 4'd1, 1'b1, 8'h55, 1'b0);
    add_row(8'h7F, KIND_PLAIN, 1'b1, 1'b1, 4'd0, 1'b1, 8'h00, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_block(directed_rows[i].blk, directed_rows[i].typed, directed_rows[i].want);

    counted_blocks = 0;
    while (counted_blocks < BLOCK_GOAL) begin
      // Once midway, hold off until the matcher has delivered everything.
      if (!drained && counted_blocks >= BLOCK_GOAL / 2) begin
        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      build_program();
      foreach (program_blocks[i]) send_block(program_blocks[i], 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("loop_bracket_matcher_unit_test OK");
    end else begin
      $display("loop_bracket_matcher_unit_test NOT OK");
    end
    $finish;
  end

endmodule
